@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl, sampled on clk and disabled in rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle or a fixed delay later
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/cart_pkg.sv @@
// package with widths, types and op codes of the range test
`default_nettype none

package cart_pkg;

  localparam int DW    = 64;
  localparam int DW_LO = DW / 2;
  localparam int DW_HI = DW - DW_LO;
  localparam int PW    = 2 * DW;

  typedef logic [DW-1:0]        data_t;
  typedef logic [PW-1:0]        prod_t;
  typedef logic signed [DW:0]   swide_t;
  typedef logic signed [PW:0]   sprod_t;

  typedef enum logic [3:0] {
    OP_UCAST = 4'd0,
    OP_SCAST = 4'd1,
    OP_UADD  = 4'd2,
    OP_USUB  = 4'd3,
    OP_UMUL  = 4'd4,
    OP_SADD  = 4'd5,
    OP_SSUB  = 4'd6,
    OP_SMUL  = 4'd7,
    OP_SDIV  = 4'd8
  } op_t;

endpackage

`default_nettype wire

@@ hw/rtl/checked_arith_range_test.sv @@
// top level of the checked arithmetic range test
`default_nettype none

// Checks one arithmetic operation per request against a lower and upper limit
// and answers safe or not. A request is taken whenever start is high; busy is
// always low, so a new request can be issued every cycle. The answer appears
// on safe together with a one-cycle done pulse, in request order. The
// pipeline depth is set by the 64 x 64 multiply, which is split into 32 x 32
// partial products: one stage registers the inputs, one the partial products,
// one their sum and one the verdict.
// The receiver cannot stall; done must be sampled when it is high.

`include "assert_macros.svh"

module checked_arith_range_test (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  op,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  input  wire logic [63:0] limit_low,
  input  wire logic [63:0] limit_high,
  output logic             done,
  output logic             safe
);

  // input stage
  logic             a_vld;
  cart_pkg::op_t    a_op;
  cart_pkg::data_t  a_a;
  cart_pkg::data_t  a_b;
  cart_pkg::data_t  a_lo;
  cart_pkg::data_t  a_hi;

  // partial product stage
  logic             b_vld;
  logic             b_umul;
  logic             b_smul;
  logic             b_ok;
  logic             b_neg;
  cart_pkg::data_t  b_lo;
  cart_pkg::data_t  b_hi;
  logic [2*cart_pkg::DW_LO-1:0]           pp_ll;
  logic [cart_pkg::DW_LO+cart_pkg::DW_HI-1:0] pp_lh;
  logic [cart_pkg::DW_HI+cart_pkg::DW_LO-1:0] pp_hl;
  logic [2*cart_pkg::DW_HI-1:0]           pp_hh;

  // product stage
  logic             c_vld;
  logic             c_umul;
  logic             c_smul;
  logic             c_ok;
  logic             c_neg;
  cart_pkg::data_t  c_lo;
  cart_pkg::data_t  c_hi;
  cart_pkg::prod_t  c_prod;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
    a_op <= cart_pkg::op_t'(op);
    a_a  <= operand_a[cart_pkg::DW-1:0];
    a_b  <= operand_b[cart_pkg::DW-1:0];
    a_lo <= limit_low[cart_pkg::DW-1:0];
    a_hi <= limit_high[cart_pkg::DW-1:0];
  end

  // checks that need no product
  logic             ule_a;
  logic             ule_b;
  logic             sin_a;
  logic             sin_b;
  logic [cart_pkg::DW:0] usum;
  cart_pkg::swide_t ssum;
  cart_pkg::swide_t sdif;
  cart_pkg::swide_t lo_w;
  cart_pkg::swide_t hi_w;
  logic             ok_next;
  logic             umul_next;
  logic             smul_next;
  cart_pkg::data_t  mag_a;
  cart_pkg::data_t  mag_b;
  cart_pkg::data_t  mx;
  cart_pkg::data_t  my;

  always_comb begin
    ule_a = a_a <= a_hi;
    ule_b = a_b <= a_hi;
    sin_a = ($signed(a_a) >= $signed(a_lo)) && ($signed(a_a) <= $signed(a_hi));
    sin_b = ($signed(a_b) >= $signed(a_lo)) && ($signed(a_b) <= $signed(a_hi));
    usum  = {1'b0, a_a} + {1'b0, a_b};
    ssum  = $signed({a_a[cart_pkg::DW-1], a_a}) + $signed({a_b[cart_pkg::DW-1], a_b});
    sdif  = $signed({a_a[cart_pkg::DW-1], a_a}) - $signed({a_b[cart_pkg::DW-1], a_b});
    lo_w  = $signed({a_lo[cart_pkg::DW-1], a_lo});
    hi_w  = $signed({a_hi[cart_pkg::DW-1], a_hi});
    umul_next = 1'b0;
    smul_next = 1'b0;
    case (a_op)
      cart_pkg::OP_UCAST: ok_next = !a_a[cart_pkg::DW-1] && (a_a != '0) && (a_a < a_hi);
      cart_pkg::OP_SCAST: ok_next = a_a < a_hi;
      cart_pkg::OP_UADD:  ok_next = ule_a && ule_b && (usum <= {1'b0, a_hi});
      cart_pkg::OP_USUB:  ok_next = a_a >= a_b;
      cart_pkg::OP_UMUL: begin
        ok_next   = ule_a && ule_b;
        umul_next = 1'b1;
      end
      cart_pkg::OP_SADD:  ok_next = sin_a && sin_b && (ssum >= lo_w) && (ssum <= hi_w);
      cart_pkg::OP_SSUB:  ok_next = sin_a && sin_b && (sdif >= lo_w) && (sdif <= hi_w);
      cart_pkg::OP_SMUL: begin
        ok_next   = sin_a && sin_b;
        smul_next = 1'b1;
      end
      cart_pkg::OP_SDIV:  ok_next = sin_a && sin_b && (a_b != '0) &&
                                    !((a_a == a_lo) && (a_b == '1));
      default:            ok_next = 1'b0;
    endcase
    mag_a = a_a[cart_pkg::DW-1] ? (~a_a + 1'b1) : a_a;
    mag_b = a_b[cart_pkg::DW-1] ? (~a_b + 1'b1) : a_b;
    mx    = smul_next ? mag_a : a_a;
    my    = smul_next ? mag_b : a_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_umul <= umul_next;
    b_smul <= smul_next;
    b_ok   <= ok_next;
    b_neg  <= a_a[cart_pkg::DW-1] ^ a_b[cart_pkg::DW-1];
    b_lo   <= a_lo;
    b_hi   <= a_hi;
    pp_ll  <= mx[cart_pkg::DW_LO-1:0] * my[cart_pkg::DW_LO-1:0];
    pp_lh  <= mx[cart_pkg::DW_LO-1:0] * my[cart_pkg::DW-1:cart_pkg::DW_LO];
    pp_hl  <= mx[cart_pkg::DW-1:cart_pkg::DW_LO] * my[cart_pkg::DW_LO-1:0];
    pp_hh  <= mx[cart_pkg::DW-1:cart_pkg::DW_LO] * my[cart_pkg::DW-1:cart_pkg::DW_LO];
  end

  cart_pkg::prod_t prod_next;

  always_comb begin
    prod_next = cart_pkg::prod_t'(pp_ll)
              + (cart_pkg::prod_t'(pp_lh) << cart_pkg::DW_LO)
              + (cart_pkg::prod_t'(pp_hl) << cart_pkg::DW_LO)
              + (cart_pkg::prod_t'(pp_hh) << (2 * cart_pkg::DW_LO));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_umul <= b_umul;
    c_smul <= b_smul;
    c_ok   <= b_ok;
    c_neg  <= b_neg;
    c_lo   <= b_lo;
    c_hi   <= b_hi;
    c_prod <= prod_next;
  end

  // verdict on the exact product
  logic             umul_ok;
  logic             smul_ok;
  logic             safe_next;
  logic [cart_pkg::PW:0] prod_ext;
  cart_pkg::sprod_t sval;
  cart_pkg::sprod_t lo_p;
  cart_pkg::sprod_t hi_p;

  always_comb begin
    umul_ok  = (c_prod[cart_pkg::PW-1:cart_pkg::DW] == '0) &&
               (c_prod[cart_pkg::DW-1:0] <= c_hi);
    prod_ext = {1'b0, c_prod};
    sval     = $signed(c_neg ? (~prod_ext + 1'b1) : prod_ext);
    lo_p     = $signed({{(cart_pkg::PW + 1 - cart_pkg::DW){c_lo[cart_pkg::DW-1]}}, c_lo});
    hi_p     = $signed({{(cart_pkg::PW + 1 - cart_pkg::DW){c_hi[cart_pkg::DW-1]}}, c_hi});
    smul_ok  = (sval >= lo_p) && (sval <= hi_p);
    if (c_umul) begin
      safe_next = c_ok && umul_ok;
    end else if (c_smul) begin
      safe_next = c_ok && smul_ok;
    end else begin
      safe_next = c_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld;
    end
    safe <= safe_next;
  end

  `CHK_IMPL(a_req_answered, start && !busy, ##4 done)
  `CHK_IMPL(a_done_has_req, done, $past(start, 4))
  `CHK_IMPL(a_unused_unsafe, done && safe, $past(op, 4) <= cart_pkg::OP_SDIV)
  `CHK_NEXT(a_stage_order, b_vld, c_vld)

endmodule

`default_nettype wire
